### src/gom_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gom_pkg
// Shared types and constants of the occupancy grid map: item layouts,
// request codes and the row store access bundle.
// ----------------------------------------------------------------------------
package gom_pkg;

   localparam int SIDE    = 64;
   localparam int ROW_AW  = $clog2(SIDE);
   localparam int COORD_W = 6;
   localparam int SIZE_W  = 7;

   localparam logic REQ_FILL  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef struct packed {
      logic               req_type;
      logic [COORD_W-1:0] pos_x;
      logic [COORD_W-1:0] pos_y;
      logic [SIZE_W-1:0]  rect_w;
      logic [SIZE_W-1:0]  rect_h;
   } req_item_type;

   typedef struct packed {
      logic               cell_blocked;
      logic               cell_on_border;
      logic [2:0]         neighbour_count;
      logic [COORD_W-1:0] nb0_x;
      logic [COORD_W-1:0] nb0_y;
      logic [COORD_W-1:0] nb1_x;
      logic [COORD_W-1:0] nb1_y;
      logic [COORD_W-1:0] nb2_x;
      logic [COORD_W-1:0] nb2_y;
      logic [COORD_W-1:0] nb3_x;
      logic [COORD_W-1:0] nb3_y;
   } rsp_item_type;

   typedef struct packed {
      logic              rd_en;
      logic [ROW_AW-1:0] rd_addr;
      logic              wr_en;
      logic [ROW_AW-1:0] wr_addr;
      logic [SIDE-1:0]   wr_data;
   } gom_mem_req_type;

endpackage

### src/grid_occupancy_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_occupancy_map
// One-bit obstacle map with rectangle fill and four-neighbour cell query.
// ----------------------------------------------------------------------------
// Fill: one row read-modify-write per cycle through the row memory port;
//   a fill that marks nothing stays in idle and writes no row.
// Query: three row reads in states Q_C, Q_S and Q_N, result registered in
//   Q_OUT once the result side is free; no new request is taken until idle.
// Reset: all cells free at once (per-row valid bits), width and height 64.
// ----------------------------------------------------------------------------
module grid_occupancy_map (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  gom_pkg::req_item_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output gom_pkg::rsp_item_type rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [2:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);
   import gom_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_FILL  = 3'd1;
   localparam logic [2:0] ST_Q_C   = 3'd2;
   localparam logic [2:0] ST_Q_S   = 3'd3;
   localparam logic [2:0] ST_Q_N   = 3'd4;
   localparam logic [2:0] ST_Q_OUT = 3'd5;

   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   localparam logic [SIZE_W-1:0] SIDE_MAX = SIZE_W'(SIDE);

   logic [SIZE_W-1:0]  grid_width_ff, grid_width_in;
   logic [SIZE_W-1:0]  grid_height_ff, grid_height_in;
   logic [SIZE_W-1:0]  w_eff, h_eff;

   logic [2:0]         state_ff, state_in;
   logic [COORD_W-1:0] pos_x_ff, pos_x_in;
   logic [COORD_W-1:0] pos_y_ff, pos_y_in;
   logic [SIDE-1:0]    mask_ff, mask_in;
   logic [SIZE_W-1:0]  rd_row_ff, rd_row_in;
   logic [SIZE_W-1:0]  end_row_ff, end_row_in;
   logic               wr_pend_ff, wr_pend_in;
   logic [ROW_AW-1:0]  wr_row_ff, wr_row_in;
   logic [SIDE-1:0]    row_c_ff, row_c_in;
   logic [SIDE-1:0]    row_s_ff, row_s_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_data_ff, rsp_data_in;

   gom_mem_req_type    mem_req;
   logic [SIDE-1:0]    rd_row;

   logic               req_fire, csr_write, fill_issue, out_free, rsp_load;
   logic [SIZE_W:0]    x_sum, y_sum;
   logic [SIZE_W-1:0]  x_end, y_end, x7, y7, rx7, ry7;
   logic               fill_live;

   logic [COORD_W-1:0] x_inc, x_dec, y_inc, y_dec;
   logic [3:0]         cand_ok;
   logic [COORD_W-1:0] cand_x [4];
   logic [COORD_W-1:0] cand_y [4];
   logic [COORD_W-1:0] nb_x [4];
   logic [COORD_W-1:0] nb_y [4];
   logic [2:0]         nb_cnt;
   logic [1:0]         src;
   logic               even_sum;

   gom_row_store u_row_store (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_row  (rd_row)
   );

   function automatic logic [SIZE_W-1:0] side_eff(input logic [SIZE_W-1:0] v);
      logic [SIZE_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = SIZE_W'(1);
      end else if (v > SIDE_MAX) begin
         r = SIDE_MAX;
      end
      return r;
   endfunction

   // configuration
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign w_eff     = side_eff(grid_width_ff);
   assign h_eff     = side_eff(grid_height_ff);

   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      if (csr_write) begin
         case (paddr[2])
            CSR_WIDTH:  grid_width_in  = pwdata[SIZE_W-1:0];
            CSR_HEIGHT: grid_height_in = pwdata[SIZE_W-1:0];
            default:    grid_width_in  = grid_width_ff;
         endcase
      end
   end

   assign prdata = (paddr[2] == CSR_HEIGHT) ? {{(32-SIZE_W){1'b0}}, grid_height_ff}
                                            : {{(32-SIZE_W){1'b0}}, grid_width_ff};

   // fill setup
   assign rx7       = {1'b0, req_data.pos_x};
   assign ry7       = {1'b0, req_data.pos_y};
   assign x_sum     = {1'b0, rx7} + {1'b0, req_data.rect_w};
   assign y_sum     = {1'b0, ry7} + {1'b0, req_data.rect_h};
   assign x_end     = (x_sum > {1'b0, w_eff}) ? w_eff : x_sum[SIZE_W-1:0];
   assign y_end     = (y_sum > {1'b0, h_eff}) ? h_eff : y_sum[SIZE_W-1:0];
   assign fill_live = (rx7 < w_eff) && (ry7 < h_eff)
                      && (req_data.rect_w != '0) && (req_data.rect_h != '0);

   always_comb begin
      for (int i = 0; i < SIDE; i++) begin
         mask_in[i] = (SIZE_W'(i) >= rx7) && (SIZE_W'(i) < x_end);
      end
   end

   // control
   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign fill_issue = (state_ff == ST_FILL) && (rd_row_ff < end_row_ff);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_load   = (state_ff == ST_Q_OUT) && out_free;

   always_comb begin
      state_in   = state_ff;
      pos_x_in   = pos_x_ff;
      pos_y_in   = pos_y_ff;
      rd_row_in  = rd_row_ff;
      end_row_in = end_row_ff;
      wr_pend_in = 1'b0;
      wr_row_in  = wr_row_ff;
      row_c_in   = row_c_ff;
      row_s_in   = row_s_ff;

      mem_req.rd_en   = 1'b0;
      mem_req.rd_addr = pos_y_ff;
      mem_req.wr_en   = wr_pend_ff;
      mem_req.wr_addr = wr_row_ff;
      mem_req.wr_data = rd_row | mask_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               pos_x_in = req_data.pos_x;
               pos_y_in = req_data.pos_y;
               if (req_data.req_type == REQ_QUERY) begin
                  state_in = ST_Q_C;
               end else if (fill_live) begin
                  rd_row_in  = ry7;
                  end_row_in = y_end;
                  state_in   = ST_FILL;
               end
            end
         end
         ST_FILL: begin
            if (fill_issue) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = rd_row_ff[ROW_AW-1:0];
               wr_pend_in      = 1'b1;
               wr_row_in       = rd_row_ff[ROW_AW-1:0];
               rd_row_in       = rd_row_ff + SIZE_W'(1);
            end else if (!wr_pend_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_Q_C: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = pos_y_ff;
            state_in        = ST_Q_S;
         end
         ST_Q_S: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = y_inc;
            row_c_in        = rd_row;
            state_in        = ST_Q_N;
         end
         ST_Q_N: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = y_dec;
            row_s_in        = rd_row;
            state_in        = ST_Q_OUT;
         end
         ST_Q_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // query evaluation; the north row is the last read, still held
   assign x7       = {1'b0, pos_x_ff};
   assign y7       = {1'b0, pos_y_ff};
   assign x_inc    = pos_x_ff + COORD_W'(1);
   assign x_dec    = pos_x_ff - COORD_W'(1);
   assign y_inc    = pos_y_ff + COORD_W'(1);
   assign y_dec    = pos_y_ff - COORD_W'(1);
   assign even_sum = (pos_x_ff[0] == pos_y_ff[0]);

   always_comb begin
      cand_ok[0] = ((x7 + SIZE_W'(1)) < w_eff) && (y7 < h_eff) && !row_c_ff[x_inc];
      cand_x[0]  = x_inc;
      cand_y[0]  = pos_y_ff;
      cand_ok[1] = (x7 < w_eff) && ((y7 + SIZE_W'(1)) < h_eff) && !row_s_ff[pos_x_ff];
      cand_x[1]  = pos_x_ff;
      cand_y[1]  = y_inc;
      cand_ok[2] = (pos_x_ff != '0) && (x7 <= w_eff) && (y7 < h_eff) && !row_c_ff[x_dec];
      cand_x[2]  = x_dec;
      cand_y[2]  = pos_y_ff;
      cand_ok[3] = (pos_y_ff != '0) && (x7 < w_eff) && (y7 <= h_eff) && !rd_row[pos_x_ff];
      cand_x[3]  = pos_x_ff;
      cand_y[3]  = y_dec;
   end

   always_comb begin
      nb_cnt = '0;
      src    = '0;
      for (int k = 0; k < 4; k++) begin
         nb_x[k] = '0;
         nb_y[k] = '0;
      end
      for (int j = 0; j < 4; j++) begin
         src = even_sum ? 2'(3 - j) : 2'(j);
         if (cand_ok[src]) begin
            nb_x[nb_cnt[1:0]] = cand_x[src];
            nb_y[nb_cnt[1:0]] = cand_y[src];
            nb_cnt            = nb_cnt + 3'd1;
         end
      end
   end

   always_comb begin
      rsp_data_in                 = rsp_data_ff;
      rsp_valid_in                = rsp_valid_ff && !rsp_ready;
      if (rsp_load) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.cell_blocked    = (x7 < w_eff) && (y7 < h_eff) && row_c_ff[pos_x_ff];
         rsp_data_in.cell_on_border  = (pos_x_ff == '0) || (x7 == w_eff - SIZE_W'(1))
                                       || (pos_y_ff == '0) || (y7 == h_eff - SIZE_W'(1));
         rsp_data_in.neighbour_count = nb_cnt;
         rsp_data_in.nb0_x           = nb_x[0];
         rsp_data_in.nb0_y           = nb_y[0];
         rsp_data_in.nb1_x           = nb_x[1];
         rsp_data_in.nb1_y           = nb_y[1];
         rsp_data_in.nb2_x           = nb_x[2];
         rsp_data_in.nb2_y           = nb_y[2];
         rsp_data_in.nb3_x           = nb_x[3];
         rsp_data_in.nb3_y           = nb_y[3];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= SIDE_MAX;
         grid_height_ff <= SIDE_MAX;
         state_ff       <= ST_IDLE;
         wr_pend_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
         state_ff       <= state_in;
         wr_pend_ff     <= wr_pend_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_x_ff    <= pos_x_in;
      pos_y_ff    <= pos_y_in;
      rd_row_ff   <= rd_row_in;
      end_row_ff  <= end_row_in;
      wr_row_ff   <= wr_row_in;
      row_c_ff    <= row_c_in;
      row_s_ff    <= row_s_in;
      rsp_data_ff <= rsp_data_in;
      if (req_fire && req_data.req_type == REQ_FILL) begin
         mask_ff <= mask_in;
      end
   end

   a_write_in_fill: assert property (@(posedge clock) disable iff (reset)
      mem_req.wr_en |-> state_ff == ST_FILL)
      else $error("row write outside fill");

   a_query_starts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.req_type == REQ_QUERY) |=> state_ff == ST_Q_C)
      else $error("query did not start reading");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FILL |-> rd_row_ff <= end_row_ff)
      else $error("fill row past end");

   a_rsp_from_query: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_Q_OUT)
      else $error("result without query");

endmodule

### src/gom_row_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gom_row_store
// Obstacle row memory, one row word per entry, with one valid bit per row
// so that unwritten rows read as free. Registered read, one write port.
// ----------------------------------------------------------------------------
module gom_row_store (
   input  logic                      clock,
   input  logic                      reset,
   input  gom_pkg::gom_mem_req_type  mem_req,
   output logic [gom_pkg::SIDE-1:0]  rd_row
);
   import gom_pkg::*;

   logic [SIDE-1:0] mem [SIDE];
   logic [SIDE-1:0] row_valid_ff;
   logic [SIDE-1:0] rd_data_ff;
   logic            rd_valid_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (mem_req.wr_en) begin
            row_valid_ff[mem_req.wr_addr] <= 1'b1;
         end
         if (mem_req.rd_en) begin
            rd_valid_ff <= row_valid_ff[mem_req.rd_addr];
         end
      end
   end

   assign rd_row = rd_valid_ff ? rd_data_ff : '0;

endmodule
